[rtl/rc_channel_frame_decoder_core_assert.svh]
// Assertion macros shared by the frame decoder RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RC_CHANNEL_FRAME_DECODER_CORE_ASSERT_SVH
`define RC_CHANNEL_FRAME_DECODER_CORE_ASSERT_SVH

// Combinational property, checked on every rising clock edge out of reset.
`define RCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rcfd_pkg.sv]
// Shared constants and types of the RC channel frame decoder.
// No dependencies; used by every module of the block.
package rcfd_pkg;

  localparam int FRAME_BYTES  = 32;
  localparam int ADDR_W       = $clog2(FRAME_BYTES);
  localparam int SUMMED_BYTES = 30;
  localparam int CHANNELS_DEF = 14;

  localparam logic [7:0]  HEADER_BYTE = 8'h20;
  localparam logic [15:0] CHECK_INIT  = 16'hFFFF;

  // write port of the frame memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } rcfd_wr_t;

endpackage

[rtl/rc_channel_frame_decoder_core.sv]
// Top level of the RC channel frame decoder: collector, frame memory, emitter.
// Depends on rcfd_pkg, rcfd_frame_ram, rcfd_collector and rcfd_emitter.
//
// Decodes 32-byte iBUS-style frames from a byte stream. Bytes are dropped until the
// header 0x20 arrives; that byte and the next 31 are written to a 32x8 frame memory
// while a running 16-bit checksum (0xFFFF minus the sum of bytes 0 to 29) is kept,
// so collection takes one byte per cycle. The checksum is compared with the
// little-endian word in bytes 30 and 31. On a match CHANNELS little-endian words
// from bytes 2 and up leave on the master side, tuser carrying the channel index
// and tlast marking the final channel; a bad frame produces no output. Emission
// reads the frame through the single read port of the memory, two reads and a
// capture per channel before the output handshake, and the input is held off
// while a good frame is being emitted. The memory needs no clearing after reset:
// every frame writes all entries before any is read.
module rc_channel_frame_decoder_core #(
  parameter int CHANNELS = rcfd_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] channel_value
  output logic [3:0]  m_axis_tuser,   // [3:0] channel_index
  output logic        m_axis_tlast    // last_channel
);

  rcfd_pkg::rcfd_wr_t          wr;
  logic [rcfd_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                  rd_data;
  logic                        frame_ok;
  logic                        emit_busy;

  // hold off input while a good frame is being emitted
  assign s_axis_tready = !emit_busy && !frame_ok;

  rcfd_collector u_collector (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid && s_axis_tready),
    .byte_i       (s_axis_tdata),
    .wr_o         (wr),
    .frame_ok_o   (frame_ok)
  );

  rcfd_frame_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rcfd_emitter #(
    .CHANNELS (CHANNELS)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_ok),
    .busy_o     (emit_busy),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

[rtl/rcfd_frame_ram.sv]
// Frame memory: one write port, one read port with registered read data.
// Depends on rcfd_pkg for depth and the write port struct.
module rcfd_frame_ram (
  input  logic                     clk_i,
  input  rcfd_pkg::rcfd_wr_t       wr_i,
  input  logic [rcfd_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem_q [rcfd_pkg::FRAME_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/rcfd_collector.sv]
// Byte collector: header hunt, frame write into memory, running checksum.
// Depends on rcfd_pkg and the assertion macro header.
`include "rc_channel_frame_decoder_core_assert.svh"

module rcfd_collector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         byte_i,
  output rcfd_pkg::rcfd_wr_t wr_o,
  output logic               frame_ok_o
);

  logic [rcfd_pkg::ADDR_W-1:0] pos_q, pos_d;
  logic [15:0]                 sum_q, sum_d;
  logic [7:0]                  lo_q, lo_d;
  logic                        frame_ok_q, frame_ok_d;
  logic                        take;

  // drop bytes while hunting unless they are the header
  assign take = byte_valid_i && ((pos_q != '0) || (byte_i == rcfd_pkg::HEADER_BYTE));

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    lo_d       = lo_q;
    frame_ok_d = 1'b0;
    if (take) begin
      pos_d = pos_q + 1'b1;
      if (pos_q == '0) begin
        sum_d = rcfd_pkg::CHECK_INIT - {8'd0, byte_i};
      end else if (pos_q < rcfd_pkg::ADDR_W'(rcfd_pkg::SUMMED_BYTES)) begin
        sum_d = sum_q - {8'd0, byte_i};
      end
      if (pos_q == rcfd_pkg::ADDR_W'(rcfd_pkg::SUMMED_BYTES)) begin
        lo_d = byte_i;
      end
      if (pos_q == rcfd_pkg::ADDR_W'(rcfd_pkg::FRAME_BYTES - 1)) begin
        frame_ok_d = (sum_q == {byte_i, lo_q});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      frame_ok_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      frame_ok_q <= frame_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    lo_q  <= lo_d;
  end

  assign wr_o.we    = take;
  assign wr_o.addr  = pos_q;
  assign wr_o.data  = byte_i;
  assign frame_ok_o = frame_ok_q;

  `RCFD_ASSERT(a_ok_after_wrap, !frame_ok_q || (pos_q == '0), "frame done but position not reset")
  `RCFD_ASSERT_NEXT(a_hunt_holds,
    byte_valid_i && (pos_q == '0) && (byte_i != rcfd_pkg::HEADER_BYTE),
    pos_q == '0, "non-header byte left hunt state")

endmodule

[rtl/rcfd_emitter.sv]
// Channel emitter: reads the stored frame word by word and drives the output stream.
// Depends on rcfd_pkg and the assertion macro header.
`include "rc_channel_frame_decoder_core_assert.svh"

module rcfd_emitter #(
  parameter int CHANNELS = rcfd_pkg::CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  output logic [rcfd_pkg::ADDR_W-1:0] rd_addr_o,
  input  logic [7:0]                  rd_data_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [15:0]                 m_tdata_o,
  output logic [3:0]                  m_tuser_o,
  output logic                        m_tlast_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_CAP,
    S_OUT
  } state_e;

  state_e      state_q;
  logic [3:0]  chan_q;
  logic [7:0]  lo_q;
  logic        valid_q;
  logic [15:0] data_q;
  logic [3:0]  user_q;
  logic        last_q;
  logic [rcfd_pkg::ADDR_W-1:0] lo_addr;

  // channel k sits at bytes 2+2k (low) and 3+2k (high)
  assign lo_addr   = rcfd_pkg::ADDR_W'({chan_q, 1'b0}) + rcfd_pkg::ADDR_W'(2);
  assign rd_addr_o = (state_q == S_HI) ? (lo_addr + 1'b1) : lo_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chan_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          chan_q <= '0;
          if (start_i) begin
            state_q <= S_LO;
          end
        end
        S_LO: state_q <= S_HI;
        S_HI: begin
          lo_q    <= rd_data_i;
          state_q <= S_CAP;
        end
        S_CAP: begin
          data_q  <= {rd_data_i, lo_q};
          user_q  <= chan_q;
          last_q  <= (chan_q == 4'(CHANNELS - 1));
          valid_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_tready_i) begin
            valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              chan_q  <= chan_q + 1'b1;
              state_q <= S_LO;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;

  `RCFD_ASSERT(a_start_idle, !start_i || (state_q == S_IDLE), "frame start while emitting")
  `RCFD_ASSERT_NEXT(a_last_ends, valid_q && m_tready_i && last_q, state_q == S_IDLE,
    "emitter kept running after last channel")
  `RCFD_ASSERT(a_index_range, !valid_q || (user_q <= 4'(CHANNELS - 1)),
    "channel index out of range")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for rc_channel_frame_decoder_core: byte stream in, channel words out.
// Uses rcfd_pkg for frame constants; a built-in decoder predicts the words of untyped frames.
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_CH    = rcfd_pkg::CHANNELS_DEF;
  localparam int HOLD_LEN  = 400;
  localparam int TAIL_WAIT = 4 * NUM_CH + 16;
  localparam int PHASE_LEN = 24;

  typedef enum logic {ROW_NOISE, ROW_FRAME} row_kind_e;
  typedef enum logic [1:0] {PAY_FILL, PAY_RAMP, PAY_RANDOM} payload_e;

  typedef struct packed {
    row_kind_e   kind;
    payload_e    pattern;
    logic [7:0]  val;       // noise byte, or fill byte of the channel area
    logic [7:0]  second;    // second header byte
    logic        bad_sum;
    logic        typed;     // expectation given in the row
    logic [15:0] exp_word;  // every channel word of a good typed frame
  } row_t;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] value;
    logic        last;
  } chan_word_t;

  localparam int NUM_ROWS = 8;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_NOISE, PAY_FILL,   8'h00, 8'h00, 1'b0, 1'b1, 16'h0000},
    '{ROW_NOISE, PAY_FILL,   8'hFF, 8'h00, 1'b0, 1'b1, 16'h0000},
    '{ROW_NOISE, PAY_FILL,   8'h1F, 8'h00, 1'b0, 1'b1, 16'h0000},
    '{ROW_NOISE, PAY_FILL,   8'h21, 8'h00, 1'b0, 1'b1, 16'h0000},
    '{ROW_FRAME, PAY_FILL,   8'h00, 8'h40, 1'b0, 1'b1, 16'h0000},
    '{ROW_FRAME, PAY_FILL,   8'hFF, 8'h40, 1'b0, 1'b1, 16'hFFFF},
    // header value inside the frame, also as second byte
    '{ROW_FRAME, PAY_FILL,   8'h20, 8'h20, 1'b0, 1'b1, 16'h2020},
    '{ROW_FRAME, PAY_FILL,   8'h5A, 8'h40, 1'b1, 1'b1, 16'h0000}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // decoder state mirrored by the testbench
  logic [5:0]  frame_pos;
  logic [7:0]  frame_bytes [rcfd_pkg::FRAME_BYTES];
  chan_word_t  pending_words [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned bytes_sent;
  int unsigned words_checked;
  int unsigned good_frames;
  int unsigned errors;
  logic        typed_now;

  rc_channel_frame_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Advance the mirrored decoder by one accepted byte; queue the channel words it yields.
  function automatic void decode_rx_byte(input logic [7:0] b);
    logic [15:0] chk;
    chan_word_t  w;
    if (frame_pos == 6'd0 && b != rcfd_pkg::HEADER_BYTE) return;
    frame_bytes[frame_pos[4:0]] = b;
    frame_pos = frame_pos + 6'd1;
    if (frame_pos < rcfd_pkg::FRAME_BYTES) return;
    frame_pos = 6'd0;
    chk = rcfd_pkg::CHECK_INIT;
    for (int i = 0; i < rcfd_pkg::SUMMED_BYTES; i++) chk = chk - {8'h00, frame_bytes[i]};
    if (chk != {frame_bytes[rcfd_pkg::SUMMED_BYTES + 1], frame_bytes[rcfd_pkg::SUMMED_BYTES]})
      return;
    if (typed_now) return;
    for (int k = 0; k < NUM_CH; k++) begin
      w.idx   = k[3:0];
      w.value = {frame_bytes[3 + 2 * k], frame_bytes[2 + 2 * k]};
      w.last  = (k == NUM_CH - 1);
      pending_words.push_back(w);
    end
  endfunction

  // Lay out a 32-byte frame with its checksum; optionally spoil the checksum.
  function automatic void build_frame(input row_t r,
                                      output logic [7:0] f [rcfd_pkg::FRAME_BYTES]);
    logic [15:0] sum;
    logic [15:0] spoil;
    f[0] = rcfd_pkg::HEADER_BYTE;
    f[1] = r.second;
    for (int i = 2; i < rcfd_pkg::SUMMED_BYTES; i++) begin
      case (r.pattern)
        PAY_FILL: begin
          f[i] = r.val;
        end
        PAY_RAMP: begin
          f[i] = 8'(i * 37 + 3);
        end
        default: begin
          f[i] = 8'($urandom_range(255));
        end
      endcase
    end
    sum = rcfd_pkg::CHECK_INIT;
    for (int i = 0; i < rcfd_pkg::SUMMED_BYTES; i++) sum = sum - {8'h00, f[i]};
    if (r.bad_sum) begin
      spoil = 16'($urandom_range(16'hFFFF, 1));
      sum = sum ^ spoil;
    end
    f[rcfd_pkg::SUMMED_BYTES]     = sum[7:0];
    f[rcfd_pkg::SUMMED_BYTES + 1] = sum[15:8];
  endfunction

  // Offer one byte, with a random gap first, and hold it until the transfer.
  task automatic push_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    decode_rx_byte(b);
  endtask

  task automatic send_frame(input row_t r);
    logic [7:0] f [rcfd_pkg::FRAME_BYTES];
    chan_word_t w;
    build_frame(r, f);
    for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++) push_byte(f[i]);
    if (r.typed && !r.bad_sum) begin
      for (int k = 0; k < NUM_CH; k++) begin
        w.idx   = k[3:0];
        w.value = r.exp_word;
        w.last  = (k == NUM_CH - 1);
        pending_words.push_back(w);
      end
    end
  endtask

  // Go quiet until every predicted channel word has left the block.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  task automatic random_frame(input logic bad);
    row_t        r;
    int unsigned pick;
    pick = $urandom_range(7);
    r = '{ROW_FRAME, PAY_RANDOM, 8'h00, 8'($urandom_range(255)), bad, 1'b0, 16'h0000};
    if (pick == 0) begin
      r.pattern = PAY_FILL;
      r.val = 8'h00;
    end else if (pick == 1) begin
      r.pattern = PAY_FILL;
      r.val = 8'hFF;
    end
    send_frame(r);
  endtask

  // Output side: stall at random, or hold off for a long stretch on request.
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each output transfer against the oldest predicted channel word.
  always @(posedge clk_i) begin
    chan_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: expected no transfer, got idx=%0d value=%h last=%b", $time,
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        if (m_axis_tlast) good_frames++;
        if (m_axis_tuser !== w.idx) begin
          errors++;
          $display("%0t: channel index expected %0d, got %0d", $time, w.idx, m_axis_tuser);
        end
        if (m_axis_tdata !== w.value) begin
          errors++;
          $display("%0t: channel value expected %h, got %h", $time, w.value, m_axis_tdata);
        end
        if (m_axis_tlast !== w.last) begin
          errors++;
          $display("%0t: last flag expected %b, got %b", $time, w.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    int unsigned phase_start;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  b;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= 8'h00;
    frame_pos      = 6'd0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;
    hold_seen      = 0;
    hold_left      = 0;
    bytes_sent     = 0;
    words_checked  = 0;
    good_frames    = 0;
    errors         = 0;
    typed_now      = 1'b0;
    for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++) frame_bytes[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      typed_now = DIRECTED_ROWS[i].typed;
      if (DIRECTED_ROWS[i].kind == ROW_NOISE) push_byte(DIRECTED_ROWS[i].val);
      else send_frame(DIRECTED_ROWS[i]);
    end
    typed_now = 1'b0;
    wait_drained();

    // Long output hold-off after a good frame while bytes keep coming: input stalls.
    hold_reqs++;
    random_frame(1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 28 : 0;
      recv_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 28 : 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_LEN) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          random_frame(1'b0);
        end else if (pick < 80) begin
          random_frame(1'b1);
        end else if (pick < 92) begin
          n = $urandom_range(5, 1);
          for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(255));
            if (b == rcfd_pkg::HEADER_BYTE) b = 8'h00;
            push_byte(b);
          end
        end else begin
          // cut the payload short, then fill the frame up with zeros
          push_byte(rcfd_pkg::HEADER_BYTE);
          n = $urandom_range(rcfd_pkg::FRAME_BYTES - 2, 1);
          for (int i = 0; i < n; i++) push_byte(8'($urandom_range(255)));
          for (int i = 0; i < rcfd_pkg::FRAME_BYTES - 1 - n; i++) push_byte(8'h00);
        end
      end
      wait_drained();
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("Sent %0d bytes in directed frames, noise and four gap/stall mixes;", bytes_sent);
    $display("checked %0d channel words from %0d good frames, with one long output hold-off.",
             words_checked, good_frames);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
